FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational relation checked at every clock
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// consequence in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/ddo_pkg.sv
package ddo_pkg;

    localparam logic [7:0] REG_MM_PER_TICK = 8'd0;
    localparam logic [7:0] REG_WHEEL_BASE  = 8'd1;

    localparam logic [23:0] MPT_RESET = 24'd212926;
    localparam logic [23:0] WB_RESET  = 24'd27085;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [30:0] DT_MAX  = 31'h7FFFFFFF;
    localparam logic [46:0] POS_MAX = 47'h7FFFFFFFFFFF;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_L,
        CMD_MUL_R,
        CMD_DT_LOAD,
        CMD_DIV_STEP,
        CMD_DT_FIN,
        CMD_CORD_H1,
        CMD_CORD_H2,
        CMD_CORD_STEP,
        CMD_CORD_SAVE1,
        CMD_CORD_SAVE2,
        CMD_R_LOAD,
        CMD_R_FIN,
        CMD_WRAP_LOAD,
        CMD_WRAP_STEP,
        CMD_MF_LO,
        CMD_MF_HI,
        CMD_MF_FIN,
        CMD_ACC
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic sel_y;
    } ddo_ctrl_t;

    typedef struct packed {
        logic div_done;
        logic cord_done;
        logic wrap_ok;
        logic dt_zero;
    } ddo_stat_t;

    function automatic logic [31:0] atan_q28(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_q28 = 32'd210828714;
            5'd1:  atan_q28 = 32'd124459457;
            5'd2:  atan_q28 = 32'd65760959;
            5'd3:  atan_q28 = 32'd33381290;
            5'd4:  atan_q28 = 32'd16755422;
            5'd5:  atan_q28 = 32'd8385879;
            5'd6:  atan_q28 = 32'd4193963;
            5'd7:  atan_q28 = 32'd2097109;
            5'd8:  atan_q28 = 32'd1048571;
            5'd9:  atan_q28 = 32'd524287;
            5'd10: atan_q28 = 32'd262144;
            5'd11: atan_q28 = 32'd131072;
            5'd12: atan_q28 = 32'd65536;
            5'd13: atan_q28 = 32'd32768;
            5'd14: atan_q28 = 32'd16384;
            5'd15: atan_q28 = 32'd8192;
            5'd16: atan_q28 = 32'd4096;
            5'd17: atan_q28 = 32'd2048;
            5'd18: atan_q28 = 32'd1024;
            5'd19: atan_q28 = 32'd512;
            5'd20: atan_q28 = 32'd256;
            5'd21: atan_q28 = 32'd128;
            5'd22: atan_q28 = 32'd64;
            5'd23: atan_q28 = 32'd32;
            5'd24: atan_q28 = 32'd16;
            5'd25: atan_q28 = 32'd8;
            5'd26: atan_q28 = 32'd4;
            5'd27: atan_q28 = 32'd2;
            5'd28: atan_q28 = 32'd1;
            default: atan_q28 = 32'd0;
        endcase
    endfunction

endpackage

FILE: hdl/ddo_datapath.sv
module ddo_datapath import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_addr,
    input  logic [23:0]        cfg_wdata,
    input  logic [31:0]        left_count,
    input  logic [31:0]        right_count,
    input  ddo_ctrl_t          ctrl,
    output ddo_stat_t          stat,
    output logic [47:0]        x_pos,
    output logic [47:0]        y_pos,
    output logic [31:0]        heading_out
);

    localparam logic [4:0] CI_LAST = 5'(CORDIC_STEPS);

    logic [23:0] mpt_reg, wb_reg;
    logic [31:0] prev_l_reg, prev_r_reg;
    logic signed [31:0] heading_reg;
    logic signed [47:0] x_sum_reg, y_sum_reg;

    logic signed [31:0] dtick_l_reg, dtick_r_reg;
    logic signed [55:0] dl_reg, dr_reg, ds_reg;
    logic diff_neg_reg;
    logic [31:0] rem_reg;
    logic [61:0] low_reg, quo_reg;
    logic [30:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        ovf_reg;
    logic signed [31:0] dt_reg;
    logic        dt_zero_reg;
    logic signed [63:0] r_reg;
    logic signed [33:0] t_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic        flip_reg;
    logic [4:0]  ci_reg;
    logic signed [26:0] c1_reg, s1_reg, c2_reg, s2_reg;
    logic [57:0] mf_lo_reg;
    logic [56:0] mf_hi_reg;
    logic signed [47:0] dx_reg, dy_reg;

    // wheel deltas
    logic signed [56:0] sum_lr, diff_lr, ds_c;
    logic [56:0] diff_mag;
    logic [23:0] wb_eff;
    logic [45:0] dt_hi;
    logic        dt_ovf;
    logic [55:0] ds_mag;
    logic [30:0] dt_mag;
    logic        r_ovf;

    always_comb begin
        sum_lr   = 57'(dl_reg) + 57'(dr_reg);
        diff_lr  = 57'(dl_reg) - 57'(dr_reg);
        ds_c     = (sum_lr + 57'(sum_lr[56])) >>> 1;
        diff_mag = diff_lr[56] ? 57'(-diff_lr) : 57'(diff_lr);
        wb_eff   = (wb_reg == 24'd0) ? 24'd1 : wb_reg;
        dt_hi    = diff_mag[56:11];
        dt_ovf   = dt_hi >= {22'd0, wb_eff};
        ds_mag   = ds_reg[55] ? 56'(-ds_reg) : 56'(ds_reg);
        dt_mag   = dt_reg[31] ? 31'(-dt_reg) : dt_reg[30:0];
        r_ovf    = {9'd0, ds_mag[55:34]} >= dt_mag;
    end

    // divider step
    logic [31:0] div_t;
    logic        div_ge;
    logic [30:0] qd;
    logic [62:0] qr;

    always_comb begin
        div_t  = {rem_reg[30:0], low_reg[61]};
        div_ge = div_t >= {1'b0, den_reg};
        qd     = ovf_reg ? DT_MAX : quo_reg[30:0];
        qr     = ovf_reg ? (63'd1 << 62) : {1'b0, quo_reg};
    end

    // cordic
    logic signed [32:0] ang, cz_load;
    logic               flip_load;
    logic signed [33:0] xs, ys, xf, yf;
    logic signed [32:0] at;
    logic signed [33:0] h2_wide;
    logic signed [26:0] c_new, s_new;

    always_comb begin
        h2_wide = t_reg - PI_Q28;
        if (ctrl.cmd == CMD_CORD_H2) begin
            ang = h2_wide[32:0];
        end else begin
            ang = 33'(heading_reg);
        end
        flip_load = 1'b0;
        cz_load   = ang;
        if (ang > HALF_PI_Q28) begin
            cz_load   = ang - 33'(PI_Q28);
            flip_load = 1'b1;
        end else if (ang < -HALF_PI_Q28) begin
            cz_load   = ang + 33'(PI_Q28);
            flip_load = 1'b1;
        end
        xs    = cy_reg >>> ci_reg;
        ys    = cx_reg >>> ci_reg;
        at    = $signed({1'b0, atan_q28(ci_reg)});
        xf    = flip_reg ? -cx_reg : cx_reg;
        yf    = flip_reg ? -cy_reg : cy_reg;
        c_new = 27'(xf >>> (30 - FRAC_BITS));
        s_new = 27'(yf >>> (30 - FRAC_BITS));
    end

    // scaled product operands
    logic signed [63:0] op_a;
    logic signed [26:0] op_b;
    logic [62:0] ua;
    logic [25:0] ub;
    logic        mf_neg;

    always_comb begin
        if (dt_zero_reg) begin
            op_a = 64'(ds_reg);
            op_b = ctrl.sel_y ? s1_reg : c1_reg;
        end else begin
            op_a = r_reg;
            op_b = ctrl.sel_y ? (c2_reg - c1_reg) : (s2_reg - s1_reg);
        end
        ua     = op_a[63] ? 63'(-op_a) : op_a[62:0];
        ub     = op_b[26] ? 26'(-op_b) : op_b[25:0];
        mf_neg = (op_a[63] ^ op_b[26]) ^ (ctrl.sel_y & dt_zero_reg);
    end

    // shared multiplier
    logic signed [32:0] ma;
    logic signed [26:0] mb;
    logic signed [59:0] prod;

    always_comb begin
        case (ctrl.cmd)
            CMD_MUL_L: begin
                ma = {dtick_l_reg[31], dtick_l_reg};
                mb = {3'b000, mpt_reg};
            end
            CMD_MUL_R: begin
                ma = {dtick_r_reg[31], dtick_r_reg};
                mb = {3'b000, mpt_reg};
            end
            CMD_MF_HI: begin
                ma = {2'b00, ua[62:32]};
                mb = {1'b0, ub};
            end
            default: begin
                ma = {1'b0, ua[31:0]};
                mb = {1'b0, ub};
            end
        endcase
        prod = ma * mb;
    end

    logic [88:0] pfull, pq;
    logic [46:0] mval;
    logic signed [47:0] mres;

    always_comb begin
        pfull = {mf_hi_reg, 32'd0} + {31'd0, mf_lo_reg};
        pq    = pfull >> FRAC_BITS;
        mval  = (pq > {42'd0, POS_MAX}) ? POS_MAX : pq[46:0];
        mres  = mf_neg ? -$signed({1'b0, mval}) : $signed({1'b0, mval});
    end

    logic signed [48:0] xs_sum, ys_sum;
    logic signed [47:0] x_sat, y_sat;

    always_comb begin
        xs_sum = 49'(x_sum_reg) + 49'(dx_reg);
        ys_sum = 49'(y_sum_reg) + 49'(dy_reg);
        if (xs_sum > 49'sd140737488355327) begin
            x_sat = 48'sh7FFFFFFFFFFF;
        end else if (xs_sum < -49'sd140737488355328) begin
            x_sat = 48'sh800000000000;
        end else begin
            x_sat = xs_sum[47:0];
        end
        if (ys_sum > 49'sd140737488355327) begin
            y_sat = 48'sh7FFFFFFFFFFF;
        end else if (ys_sum < -49'sd140737488355328) begin
            y_sat = 48'sh800000000000;
        end else begin
            y_sat = ys_sum[47:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpt_reg     <= MPT_RESET;
            wb_reg      <= WB_RESET;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            heading_reg <= '0;
            x_sum_reg   <= '0;
            y_sum_reg   <= '0;
        end else begin
            if (cfg_we && cfg_addr == REG_MM_PER_TICK) begin
                mpt_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_WHEEL_BASE) begin
                wb_reg <= cfg_wdata;
            end
            if (ctrl.cmd == CMD_LOAD) begin
                prev_l_reg <= left_count;
                prev_r_reg <= right_count;
            end
            if (ctrl.cmd == CMD_ACC) begin
                x_sum_reg <= x_sat;
                y_sum_reg <= y_sat;
                if (!dt_zero_reg) begin
                    heading_reg <= h2_wide[31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            CMD_LOAD: begin
                dtick_l_reg <= left_count - prev_l_reg;
                dtick_r_reg <= right_count - prev_r_reg;
            end
            CMD_MUL_L: dl_reg <= prod[55:0];
            CMD_MUL_R: dr_reg <= prod[55:0];
            CMD_DT_LOAD: begin
                ds_reg       <= ds_c[55:0];
                diff_neg_reg <= diff_lr[56];
                ovf_reg      <= dt_ovf;
                rem_reg      <= {8'd0, dt_hi[23:0]};
                low_reg      <= {diff_mag[10:0], 51'd0};
                quo_reg      <= '0;
                den_reg      <= {7'd0, wb_eff};
                cnt_reg      <= dt_ovf ? 6'd0 : 6'd31;
            end
            CMD_R_LOAD: begin
                ovf_reg <= r_ovf;
                rem_reg <= {10'd0, ds_mag[55:34]};
                low_reg <= {ds_mag[33:0], 28'd0};
                quo_reg <= '0;
                den_reg <= dt_mag;
                cnt_reg <= r_ovf ? 6'd0 : 6'd62;
            end
            CMD_DIV_STEP: begin
                rem_reg <= div_ge ? (div_t - {1'b0, den_reg}) : div_t;
                low_reg <= {low_reg[60:0], 1'b0};
                quo_reg <= {quo_reg[60:0], div_ge};
                cnt_reg <= cnt_reg - 6'd1;
            end
            CMD_DT_FIN: begin
                dt_reg      <= diff_neg_reg ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
                dt_zero_reg <= (qd == 31'd0);
            end
            CMD_R_FIN: begin
                r_reg <= (ds_reg[55] ^ dt_reg[31]) ? -$signed({1'b0, qr})
                                                   : $signed({1'b0, qr});
            end
            CMD_WRAP_LOAD: t_reg <= 34'(heading_reg) + 34'(dt_reg) + PI_Q28;
            CMD_WRAP_STEP: begin
                if (t_reg[33]) begin
                    t_reg <= t_reg + TWO_PI_Q28;
                end else begin
                    t_reg <= t_reg - TWO_PI_Q28;
                end
            end
            CMD_CORD_H1, CMD_CORD_H2: begin
                cz_reg   <= cz_load;
                flip_reg <= flip_load;
                cx_reg   <= GAIN_Q30;
                cy_reg   <= '0;
                ci_reg   <= '0;
            end
            CMD_CORD_STEP: begin
                if (!cz_reg[32]) begin
                    cx_reg <= cx_reg - xs;
                    cy_reg <= cy_reg + ys;
                    cz_reg <= cz_reg - at;
                end else begin
                    cx_reg <= cx_reg + xs;
                    cy_reg <= cy_reg - ys;
                    cz_reg <= cz_reg + at;
                end
                ci_reg <= ci_reg + 5'd1;
            end
            CMD_CORD_SAVE1: begin
                c1_reg <= c_new;
                s1_reg <= s_new;
            end
            CMD_CORD_SAVE2: begin
                c2_reg <= c_new;
                s2_reg <= s_new;
            end
            CMD_MF_LO: mf_lo_reg <= prod[57:0];
            CMD_MF_HI: mf_hi_reg <= prod[56:0];
            CMD_MF_FIN: begin
                if (ctrl.sel_y) begin
                    dy_reg <= mres;
                end else begin
                    dx_reg <= mres;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.div_done  = (cnt_reg == 6'd0);
        stat.cord_done = (ci_reg == CI_LAST);
        stat.wrap_ok   = !t_reg[33] && (t_reg < TWO_PI_Q28);
        stat.dt_zero   = dt_zero_reg;
    end

    assign x_pos       = x_sum_reg;
    assign y_pos       = y_sum_reg;
    assign heading_out = heading_reg;

endmodule

FILE: hdl/ddo_ctrl.sv
`include "assert_macros.svh"

module ddo_ctrl import ddo_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ddo_stat_t stat,
    output ddo_ctrl_t ctrl
);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_L, S_MUL_R, S_DT_LOAD, S_DT_DIV, S_DT_FIN,
        S_C1_LOAD, S_C1_RUN, S_C1_SAVE, S_R_LOAD, S_R_DIV, S_R_FIN,
        S_W_LOAD, S_W_STEP, S_C2_LOAD, S_C2_RUN, S_C2_SAVE,
        S_MX_LO, S_MX_HI, S_MX_FIN, S_MY_LO, S_MY_HI, S_MY_FIN, S_ACC
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        ctrl.cmd   = CMD_NONE;
        ctrl.sel_y = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.cmd   = CMD_LOAD;
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L: begin ctrl.cmd = CMD_MUL_L; state_next = S_MUL_R; end
            S_MUL_R: begin ctrl.cmd = CMD_MUL_R; state_next = S_DT_LOAD; end
            S_DT_LOAD: begin ctrl.cmd = CMD_DT_LOAD; state_next = S_DT_DIV; end
            S_DT_DIV: begin
                if (stat.div_done) begin
                    state_next = S_DT_FIN;
                end else begin
                    ctrl.cmd = CMD_DIV_STEP;
                end
            end
            S_DT_FIN: begin ctrl.cmd = CMD_DT_FIN; state_next = S_C1_LOAD; end
            S_C1_LOAD: begin ctrl.cmd = CMD_CORD_H1; state_next = S_C1_RUN; end
            S_C1_RUN: begin
                if (stat.cord_done) begin
                    state_next = S_C1_SAVE;
                end else begin
                    ctrl.cmd = CMD_CORD_STEP;
                end
            end
            S_C1_SAVE: begin
                ctrl.cmd   = CMD_CORD_SAVE1;
                state_next = stat.dt_zero ? S_MX_LO : S_R_LOAD;
            end
            S_R_LOAD: begin ctrl.cmd = CMD_R_LOAD; state_next = S_R_DIV; end
            S_R_DIV: begin
                if (stat.div_done) begin
                    state_next = S_R_FIN;
                end else begin
                    ctrl.cmd = CMD_DIV_STEP;
                end
            end
            S_R_FIN: begin ctrl.cmd = CMD_R_FIN; state_next = S_W_LOAD; end
            S_W_LOAD: begin ctrl.cmd = CMD_WRAP_LOAD; state_next = S_W_STEP; end
            S_W_STEP: begin
                if (stat.wrap_ok) begin
                    state_next = S_C2_LOAD;
                end else begin
                    ctrl.cmd = CMD_WRAP_STEP;
                end
            end
            S_C2_LOAD: begin ctrl.cmd = CMD_CORD_H2; state_next = S_C2_RUN; end
            S_C2_RUN: begin
                if (stat.cord_done) begin
                    state_next = S_C2_SAVE;
                end else begin
                    ctrl.cmd = CMD_CORD_STEP;
                end
            end
            S_C2_SAVE: begin ctrl.cmd = CMD_CORD_SAVE2; state_next = S_MX_LO; end
            S_MX_LO: begin ctrl.cmd = CMD_MF_LO; state_next = S_MX_HI; end
            S_MX_HI: begin ctrl.cmd = CMD_MF_HI; state_next = S_MX_FIN; end
            S_MX_FIN: begin ctrl.cmd = CMD_MF_FIN; state_next = S_MY_LO; end
            S_MY_LO: begin
                ctrl.cmd = CMD_MF_LO; ctrl.sel_y = 1'b1; state_next = S_MY_HI;
            end
            S_MY_HI: begin
                ctrl.cmd = CMD_MF_HI; ctrl.sel_y = 1'b1; state_next = S_MY_FIN;
            end
            S_MY_FIN: begin
                ctrl.cmd = CMD_MF_FIN; ctrl.sel_y = 1'b1; state_next = S_ACC;
            end
            S_ACC: begin
                if (out_free) begin
                    ctrl.cmd   = CMD_ACC;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (ctrl.cmd == CMD_ACC) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `ASSERT_NEXT(one_item_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ASSERT_ALWAYS(acc_needs_free_out, aclk, aresetn, (ctrl.cmd != CMD_ACC) || out_free)
    `ASSERT_NEXT(acc_shows_result, aclk, aresetn, ctrl.cmd == CMD_ACC, m_tvalid)
    `ASSERT_ALWAYS(no_step_past_done, aclk, aresetn, (ctrl.cmd != CMD_DIV_STEP) || !stat.div_done)

endmodule

FILE: hdl/differential_drive_odometry.sv
// the bit-serial divider (31 and 62 steps) and the one-iteration-a-cycle cordic,
// run twice on a turn, are the iterative parts of the computation
// throughput: one item at a time, the next can be taken as the result comes out
// reset: synchronous active low, clears counts, heading and sums, restores
// mm_per_tick and wheel_base defaults
module differential_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // left_count, right_count
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // x_pos, y_pos, heading_out
);

    ddo_ctrl_t   ctrl;
    ddo_stat_t   stat;
    logic [47:0] x_pos, y_pos;
    logic [31:0] heading_out;

    ddo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ddo_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .left_count  (s_tdata[31:0]),
        .right_count (s_tdata[63:32]),
        .ctrl        (ctrl),
        .stat        (stat),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .heading_out (heading_out)
    );

    assign m_tdata = {heading_out, y_pos, x_pos};

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STALL_LIMIT = 5000;
    localparam int  SETTLE      = 300;
    localparam longint POS_HI   = 64'sh00007FFFFFFFFFFF;
    localparam longint POS_LO   = -POS_HI - 1;
    localparam longint PI_L     = longint'(ddo_pkg::PI_Q28);
    localparam longint TWO_PI_L = longint'(ddo_pkg::TWO_PI_Q28);
    localparam longint HALF_PI_L = longint'(ddo_pkg::HALF_PI_Q28);
    localparam longint GAIN_L   = longint'(ddo_pkg::GAIN_Q30);

    typedef struct {
        logic [47:0] x;
        logic [47:0] y;
        logic [31:0] h;
    } pose_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [7:0]   cfg_addr;
    logic [23:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // left_count, right_count
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // x_pos, y_pos, heading_out

    differential_drive_odometry dut (.*);

    // predictor state
    bit [23:0]   ticks_mm;
    bit [23:0]   base_mm;
    bit [31:0]   last_left;
    bit [31:0]   last_right;
    longint      pose_heading;
    longint      pose_x;
    longint      pose_y;
    longint      arc_tab [30];

    pose_t       pose_q [$];
    int          errors;
    int          idle_pct;
    int          quiet_cycles;
    bit [31:0]   cur_left;
    bit [31:0]   cur_right;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint wrap_q28(longint a);
        longint t;
        t = (a + PI_L) % TWO_PI_L;
        if (t < 0) t += TWO_PI_L;
        return t - PI_L;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = wrap_q28(ang);
        x = GAIN_L;
        y = 0;
        flip = 0;
        if (z > HALF_PI_L) begin
            z -= PI_L;
            flip = 1;
        end else if (z < -HALF_PI_L) begin
            z += PI_L;
            flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x -= xs; y += ys; z -= arc_tab[i];
            end else begin
                x += xs; y -= ys; z += arc_tab[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x >>> 14;
        s = y >>> 14;
    endfunction

    function automatic longint scaled_mul(longint a, longint b);
        longint unsigned ua, ub, hi, lo, m;
        bit neg;
        ua = magn(a);
        ub = magn(b);
        neg = (a < 0) != (b < 0);
        hi = (ua >> 32) * ub;
        lo = (ua & 64'hFFFFFFFF) * ub;
        if (hi > (longint'(POS_HI) >> 16)) begin
            m = POS_HI;
        end else begin
            m = (hi << 16) + (lo >> 16);
            if (m > POS_HI) m = POS_HI;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint turn_angle(longint diff);
        longint unsigned u, wb, q1, q;
        u = magn(diff);
        wb = (base_mm == 0) ? 1 : base_mm;
        q1 = u / wb;
        if (q1 >= 64'd2048) begin
            q = 64'h7FFFFFFF;
        end else begin
            q = (q1 << 20) + ((u % wb) << 20) / wb;
            if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
        end
        return diff < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint arc_radius(longint ds, longint dt);
        longint unsigned u, v, q1, q;
        u = magn(ds);
        v = magn(dt);
        q1 = u / v;
        if (q1 >= (64'd1 << 34)) begin
            q = 64'd1 << 62;
        end else begin
            q = (q1 << 28) + ((u % v) << 28) / v;
            if (q > (64'd1 << 62)) q = 64'd1 << 62;
        end
        return ((ds < 0) != (dt < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint t;
        t = a + b;
        if (t > POS_HI) return POS_HI;
        if (t < POS_LO) return POS_LO;
        return t;
    endfunction

    function automatic pose_t advance_pose(bit [31:0] lc, bit [31:0] rc);
        longint dl, dr, ds, dt, dx, dy, c1, s1, c2, s2, r, h2;
        int tl, tr;
        pose_t p;
        tl = int'(lc - last_left);
        tr = int'(rc - last_right);
        dl = longint'(tl) * longint'(ticks_mm);
        dr = longint'(tr) * longint'(ticks_mm);
        ds = (dl + dr) / 2;
        dt = turn_angle(dl - dr);
        last_left = lc;
        last_right = rc;
        sin_cos(pose_heading, c1, s1);
        if (dt == 0) begin
            dx = scaled_mul(ds, c1);
            dy = -scaled_mul(ds, s1);
        end else begin
            r = arc_radius(ds, dt);
            h2 = wrap_q28(pose_heading + dt);
            sin_cos(h2, c2, s2);
            dx = scaled_mul(r, s2 - s1);
            dy = scaled_mul(r, c2 - c1);
            pose_heading = h2;
        end
        pose_x = sat_sum(pose_x, dx);
        pose_y = sat_sum(pose_y, dy);
        p.x = pose_x[47:0];
        p.y = pose_y[47:0];
        p.h = pose_heading[31:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_sample(bit [31:0] lc, bit [31:0] rc);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {rc, lc};
        do @(posedge aclk); while (!s_tready);
        pose_q.push_back(advance_pose(lc, rc));
        cur_left = lc;
        cur_right = rc;
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tdata = {$urandom, $urandom};
    endtask

    task automatic drain;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [7:0] addr, logic [23:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        cfg_addr = 8'($urandom);
        cfg_wdata = 24'($urandom);
        if (addr == ddo_pkg::REG_MM_PER_TICK) ticks_mm = val;
        else if (addr == ddo_pkg::REG_WHEEL_BASE) base_mm = val;
    endtask

    task automatic set_geometry(logic [23:0] mpt, logic [23:0] wb);
        drain();
        write_reg(ddo_pkg::REG_MM_PER_TICK, mpt);
        write_reg(ddo_pkg::REG_WHEEL_BASE, wb);
    endtask

    task automatic test_first_samples;
        send_sample(32'd1000, 32'd1000);
        send_sample(32'd1000, 32'd1500);
        send_sample(32'h80000000, 32'h7FFFFFFF);
        send_sample(32'h7FFFFFFF, 32'h80000000);
        send_sample(32'hFFFFFFFF, 32'h00000000);
    endtask

    task automatic test_counter_wrap;
        send_sample(32'h7FFFFF00, 32'h7FFFFF00);
        send_sample(32'h80000010, 32'h80000010);
        send_sample(32'hFFFFFFF0, 32'hFFFFFFE0);
        send_sample(32'h00000010, 32'h00000030);
    endtask

    task automatic test_huge_turn;
        set_geometry(ddo_pkg::MPT_RESET, 24'd1);
        send_sample(cur_left + 32'd1000000, cur_right - 32'd1000000);
        send_sample(cur_left - 32'd3, cur_right + 32'd900);
    endtask

    task automatic test_zero_base;
        set_geometry(ddo_pkg::MPT_RESET, 24'd0);
        send_sample(cur_left + 32'd40, cur_right + 32'd10);
        send_sample(cur_left + 32'd5, cur_right + 32'd5);
    endtask

    task automatic test_tiny_turn;
        set_geometry(24'd1, 24'hFFFFFF);
        send_sample(cur_left + 32'd5000, cur_right + 32'd4995);
        send_sample(cur_left - 32'd700, cur_right - 32'd690);
    endtask

    task automatic test_huge_radius;
        set_geometry(24'd16, 24'hFFFFFF);
        send_sample(cur_left + 32'h7FFFFFFF, cur_right + 32'h7FFFFFFE);
        send_sample(cur_left - 32'h7FFFFFFF, cur_right - 32'h7FFFFFFE);
    endtask

    task automatic test_bad_index;
        drain();
        write_reg(8'd2, 24'h123456);
        write_reg(8'hFF, 24'hFFFFFF);
        send_sample(cur_left + 32'd77, cur_right + 32'd33);
        set_geometry(ddo_pkg::MPT_RESET, ddo_pkg::WB_RESET);
        send_sample(cur_left + 32'd120, cur_right + 32'd90);
    endtask

    task automatic random_phase(logic [23:0] mpt, logic [23:0] wb, int n, int pct);
        int kind;
        set_geometry(mpt, wb);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                send_sample($urandom, $urandom);
            end else if (kind < 30) begin
                send_sample(cur_left + $urandom_range(400), cur_right + $urandom_range(400));
            end else if (kind < 40) begin
                send_sample(cur_left - $urandom_range(60000), cur_right + $urandom_range(60000));
            end else begin
                // small steady motion, straight or gently turning
                send_sample(cur_left + 32'd50 + $urandom_range(4),
                            cur_right + 32'd50 + $urandom_range(4) - 32'd2);
            end
        end
    endtask

    task automatic test_random;
        random_phase(ddo_pkg::MPT_RESET, ddo_pkg::WB_RESET, 190, 34);
        random_phase(24'd1, 24'hFFFFFF, 190, 34);
        random_phase(24'hFFFFFF, 24'd1, 190, 0);
        random_phase(24'($urandom), 24'($urandom), 190, 34);
        random_phase(24'($urandom_range(1, 2000000)), 24'd0, 190, 34);
        idle_pct = 34;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        pose_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pose_q.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[63:0], 64'd0);
            end else begin
                want = pose_q.pop_front();
                if (m_tdata[47:0] !== want.x)
                    report_mismatch("x_pos", m_tdata[47:0], want.x);
                if (m_tdata[95:48] !== want.y)
                    report_mismatch("y_pos", m_tdata[95:48], want.y);
                if (m_tdata[127:96] !== want.h)
                    report_mismatch("heading", m_tdata[127:96], want.h);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        arc_tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
                    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
                    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
        errors = 0;
        quiet_cycles = 0;
        idle_pct = 34;
        ticks_mm = ddo_pkg::MPT_RESET;
        base_mm = ddo_pkg::WB_RESET;
        last_left = 0;
        last_right = 0;
        pose_heading = 0;
        pose_x = 0;
        pose_y = 0;
        cur_left = 0;
        cur_right = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_first_samples();
        test_counter_wrap();
        test_huge_turn();
        test_zero_base();
        test_tiny_turn();
        test_huge_radius();
        test_bad_index();
        test_random();

        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/ddo_pkg.sv
hdl/ddo_datapath.sv
hdl/ddo_ctrl.sv
hdl/differential_drive_odometry.sv
verif/tb_top.sv
